>>> hw/rtl/htm_pkg.sv
// ----------------------------------------------------------------------------
// htm_pkg: shared definitions for the heading turn and move step block
// Field widths, fixed-point constants, the CORDIC arctangent table and the
// position saturation helper used by the datapath modules.
// ----------------------------------------------------------------------------
package htm_pkg;

    // Rotation count of the CORDIC unit, limited to the size of its table.
    localparam int CORDIC_ITERATIONS = 16;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
    localparam int STEP_W            = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    // Width of the saturated position state.
    localparam int POSITION_WIDTH = 32;
    localparam int POS_SUM_W      = ((POSITION_WIDTH > 32) ? POSITION_WIDTH : 32) + 2;

    // Field widths of the input and result words.
    localparam int COORD_W  = 32;
    localparam int HEAD_W   = 17;
    localparam int RATE_W   = 20;
    localparam int DT_W     = 10;
    localparam int SPEED_W  = 20;

    // Input word layout, lowest bit first.
    localparam int IN_RESTART_LSB = 0;
    localparam int IN_TURN_LSB    = 1;
    localparam int IN_MOVE_LSB    = 2;
    localparam int IN_TARGET_LSB  = 3;
    localparam int IN_RATE_LSB    = IN_TARGET_LSB + HEAD_W;
    localparam int IN_DT_LSB      = IN_RATE_LSB + RATE_W;
    localparam int IN_SPEED_LSB   = IN_DT_LSB + DT_W;
    localparam int IN_W           = IN_SPEED_LSB + SPEED_W;
    localparam int IN_DATA_W      = ((IN_W + 7) / 8) * 8;

    // Result word layout, lowest bit first.
    localparam int OUT_W      = COORD_W + COORD_W + HEAD_W;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_X       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_Y       = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_HEADING = 2'd2;

    // Angles in degrees with 8 fraction bits.
    localparam int FULL_TURN_Q8    = 92160;
    localparam int HALF_TURN_Q8    = 46080;
    localparam int QUARTER_TURN_Q8 = 23040;

    // Turn arithmetic: step width, arc compare width, heading sum width.
    localparam int TURN_PROD_W = DT_W + RATE_W;
    localparam int TURN_STEP_W = TURN_PROD_W + 1 - 8;
    localparam int ARC_W       = HEAD_W + 3;
    localparam int WRAP_W      = 24;
    localparam int WRAP_K_W    = 3;
    localparam int WRAP_TOP_K  = 5;

    // CORDIC formats: sine and cosine Q30, angle in degrees Q16.
    localparam int TRIG_W  = 33;
    localparam int ANGLE_W = 26;
    localparam int HP_W    = HEAD_W + 2;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    // Move arithmetic: distance, product and rounded offset.
    localparam int DIST_W      = DT_W + SPEED_W;
    localparam int PROD_W      = TRIG_W + DIST_W + 1;
    localparam int ROUND_SHIFT = 38;
    localparam int OFF_W       = PROD_W - ROUND_SHIFT;

    // Sine and cosine from the rotation unit.
    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_q30;
        logic signed [TRIG_W-1:0] cos_q30;
    } t_trig;

    // Arctangent of 2^-i in degrees Q16.
    function automatic logic signed [ANGLE_W-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ANGLE_W-1:0] val;
        case (idx)
            5'd0:    val = 26'sd2949120;
            5'd1:    val = 26'sd1740967;
            5'd2:    val = 26'sd919879;
            5'd3:    val = 26'sd466945;
            5'd4:    val = 26'sd234379;
            5'd5:    val = 26'sd117306;
            5'd6:    val = 26'sd58666;
            5'd7:    val = 26'sd29335;
            5'd8:    val = 26'sd14668;
            5'd9:    val = 26'sd7334;
            5'd10:   val = 26'sd3667;
            5'd11:   val = 26'sd1833;
            5'd12:   val = 26'sd917;
            5'd13:   val = 26'sd458;
            5'd14:   val = 26'sd229;
            5'd15:   val = 26'sd115;
            5'd16:   val = 26'sd57;
            5'd17:   val = 26'sd29;
            5'd18:   val = 26'sd14;
            5'd19:   val = 26'sd7;
            5'd20:   val = 26'sd4;
            5'd21:   val = 26'sd2;
            5'd22:   val = 26'sd1;
            default: val = 26'sd0;
        endcase
        return val;
    endfunction

    // Clamp a wide signed value into the position range.
    function automatic logic signed [POSITION_WIDTH-1:0] sat_pos(
        input logic signed [POS_SUM_W-1:0] v
    );
        logic [POS_SUM_W-POSITION_WIDTH:0] upper;
        logic signed [POSITION_WIDTH-1:0]  res;
        upper = v[POS_SUM_W-1:POSITION_WIDTH-1];
        if ((&upper) || (~|upper)) begin
            res = v[POSITION_WIDTH-1:0];
        end else if (v[POS_SUM_W-1]) begin
            res = {1'b1, {(POSITION_WIDTH-1){1'b0}}};
        end else begin
            res = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/htm_cordic.sv
// ----------------------------------------------------------------------------
// htm_cordic: iterative CORDIC rotation unit
// One rotation per cycle on shared x, y and angle adders; produces sine and
// cosine in Q30 of an angle within plus or minus 90 degrees.
// ----------------------------------------------------------------------------
module htm_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [htm_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                o_done,
    output htm_pkg::t_trig                      o_trig
);
    import htm_pkg::*;

    logic signed [TRIG_W-1:0]  r_x;
    logic signed [TRIG_W-1:0]  r_y;
    logic signed [ANGLE_W-1:0] r_z;
    logic [STEP_W-1:0]         r_idx;
    logic                      r_busy;
    logic                      r_done;

    logic signed [TRIG_W-1:0]  n_x;
    logic signed [TRIG_W-1:0]  n_y;
    logic signed [ANGLE_W-1:0] n_z;
    logic signed [TRIG_W-1:0]  w_x_sh;
    logic signed [TRIG_W-1:0]  w_y_sh;
    logic signed [ANGLE_W-1:0] w_atan;
    logic                      w_last;

    // One rotation toward zero residual angle; shifts round toward minus infinity.
    always_comb begin
        w_x_sh = r_x >>> r_idx;
        w_y_sh = r_y >>> r_idx;
        w_atan = atan_q16(5'(r_idx));
        if (!r_z[ANGLE_W-1]) begin
            n_x = r_x - w_y_sh;
            n_y = r_y + w_x_sh;
            n_z = r_z - w_atan;
        end else begin
            n_x = r_x + w_y_sh;
            n_y = r_y - w_x_sh;
            n_z = r_z + w_atan;
        end
    end

    assign w_last = (r_idx == STEP_W'(CORDIC_STEPS - 1));

    // Sequencing of the rotation count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Vector and angle registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= CORDIC_GAIN_Q30;
            r_y   <= '0;
            r_z   <= i_angle;
            r_idx <= '0;
        end else if (r_busy) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_idx <= r_idx + 1'b1;
        end
    end

    assign o_done         = r_done;
    assign o_trig.sin_q30 = r_y;
    assign o_trig.cos_q30 = r_x;

endmodule

>>> hw/rtl/htm_mul.sv
// ----------------------------------------------------------------------------
// htm_mul: registered signed multiplier
// Multiplies a Q30 sine or cosine by the travel distance; the product is
// registered before any further arithmetic.
// ----------------------------------------------------------------------------
module htm_mul (
    input  logic                                i_clk,
    input  logic signed [htm_pkg::TRIG_W-1:0]   i_a,
    input  logic [htm_pkg::DIST_W-1:0]          i_b,
    output logic signed [htm_pkg::PROD_W-1:0]   o_p
);
    import htm_pkg::*;

    logic signed [DIST_W:0]   w_b;
    logic signed [PROD_W-1:0] w_p;
    logic signed [PROD_W-1:0] r_p;

    // The distance is unsigned, so it enters with a zero sign bit.
    assign w_b = $signed({1'b0, i_b});
    assign w_p = i_a * w_b;

    always_ff @(posedge i_clk) begin
        r_p <= w_p;
    end

    assign o_p = r_p;

endmodule

>>> hw/rtl/heading_turn_and_move_step.sv
// ----------------------------------------------------------------------------
// heading_turn_and_move_step: heading turn and position advance
// Keeps a heading and an x,y position; each word may reload them, turn the
// heading toward a target and advance the position along the heading.
// ----------------------------------------------------------------------------
// A word is taken only while the block is idle and yields one result word.
// With neither a turn nor a move the word goes straight to the final state,
// where the result is loaded; it is offered, and the block is ready again,
// in the same cycle. A turn adds the setup states ST_TURN0 and ST_TURN1, six
// restoring steps of the heading wrap and one fix-up; a move runs the CORDIC
// rotation unit, one rotation a cycle, followed by two passes through one
// registered multiplier. A stalled result holds the block in its last state
// until the result register frees. Position saturates to POSITION_WIDTH
// bits; the result carries its low 32 bits. Configuration writes take effect
// at once and are meant for idle time.
// ----------------------------------------------------------------------------
module heading_turn_and_move_step (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [htm_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [htm_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // restart, turn_enable, move_enable, target_angle, turn_rate, delta_time, speed
    input  logic [htm_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // out_x, out_y, out_heading
    output logic [htm_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
    import htm_pkg::*;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_TURN0 = 4'd1;
    localparam logic [3:0] ST_TURN1 = 4'd2;
    localparam logic [3:0] ST_WRAP  = 4'd3;
    localparam logic [3:0] ST_WFIX  = 4'd4;
    localparam logic [3:0] ST_MOVE0 = 4'd5;
    localparam logic [3:0] ST_CORD  = 4'd6;
    localparam logic [3:0] ST_MUL_S = 4'd7;
    localparam logic [3:0] ST_MUL_C = 4'd8;
    localparam logic [3:0] ST_MUL_E = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    localparam logic signed [WRAP_W-1:0] FULL_W    = WRAP_W'(FULL_TURN_Q8);
    localparam logic signed [ARC_W-1:0]  FULL_A    = ARC_W'(FULL_TURN_Q8);
    localparam logic signed [HP_W-1:0]   FULL_H    = HP_W'(FULL_TURN_Q8);
    localparam logic signed [HP_W-1:0]   HALF_H    = HP_W'(HALF_TURN_Q8);
    localparam logic signed [HP_W-1:0]   QUARTER_H = HP_W'(QUARTER_TURN_Q8);
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (ROUND_SHIFT - 1);

    // Control and state registers.
    logic [3:0]                       r_state, n_state;
    logic signed [COORD_W-1:0]        r_start_x;
    logic signed [COORD_W-1:0]        r_start_y;
    logic [HEAD_W-1:0]                r_start_heading;
    logic signed [POSITION_WIDTH-1:0] r_cur_x, n_cur_x;
    logic signed [POSITION_WIDTH-1:0] r_cur_y, n_cur_y;
    logic [HEAD_W-1:0]                r_cur_heading, n_cur_heading;
    logic                             r_m_valid, n_m_valid;

    // Item and datapath registers.
    logic                             r_move_en;
    logic [HEAD_W-1:0]                r_target;
    logic [RATE_W-1:0]                r_rate;
    logic [DT_W-1:0]                  r_dt;
    logic [SPEED_W-1:0]               r_speed;
    logic [TURN_STEP_W-1:0]           r_step;
    logic                             r_down;
    logic signed [WRAP_W-1:0]         r_v;
    logic                             r_neg;
    logic [WRAP_K_W-1:0]              r_k;
    logic [DIST_W-1:0]                r_dist;
    logic                             r_neg_cos;
    logic [OUT_DATA_W-1:0]            r_m_data;

    // Combinational signals.
    logic                             w_accept;
    logic                             w_in_restart;
    logic                             w_in_turn;
    logic                             w_in_move;
    logic [TURN_PROD_W-1:0]           w_turn_prod;
    logic [TURN_PROD_W:0]             w_turn_rnd;
    logic signed [HEAD_W+1:0]         w_e;
    logic signed [ARC_W-1:0]          w_e2;
    logic signed [ARC_W-1:0]          w_diff;
    logic signed [WRAP_W-1:0]         w_h_ext;
    logic signed [WRAP_W-1:0]         w_step_ext;
    logic signed [WRAP_W-1:0]         w_turned;
    logic signed [WRAP_W-1:0]         w_mult;
    logic signed [WRAP_W-1:0]         w_cand;
    logic                             w_take;
    logic signed [WRAP_W-1:0]         w_fixed;
    logic signed [HP_W-1:0]           w_h0;
    logic signed [HP_W-1:0]           w_h1;
    logic signed [HP_W-1:0]           w_h2;
    logic signed [HP_W-1:0]           w_h3;
    logic                             w_neg_cos;
    logic signed [HP_W+7:0]           w_zw;
    logic signed [ANGLE_W-1:0]        w_z0;
    logic [DIST_W-1:0]                w_dist;
    logic                             w_cordic_done;
    t_trig                            w_trig;
    logic signed [TRIG_W-1:0]         w_mul_a;
    logic signed [PROD_W-1:0]         w_prod;
    logic signed [PROD_W-1:0]         w_off_sum;
    logic signed [OFF_W-1:0]          w_off;
    logic signed [POS_SUM_W-1:0]      w_x_ext;
    logic signed [POS_SUM_W-1:0]      w_y_ext;
    logic signed [POS_SUM_W-1:0]      w_off_ext;
    logic signed [POSITION_WIDTH-1:0] w_new_x;
    logic signed [POSITION_WIDTH-1:0] w_new_y;
    logic signed [POSITION_WIDTH-1:0] w_load_x;
    logic signed [POSITION_WIDTH-1:0] w_load_y;
    logic                             w_load_out;

    // Input handshake and field extraction.
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_restart  = s_axis_tdata[IN_RESTART_LSB];
    assign w_in_turn     = s_axis_tdata[IN_TURN_LSB];
    assign w_in_move     = s_axis_tdata[IN_MOVE_LSB];

    // Turn step, rounded half up to degrees Q8.
    assign w_turn_prod = TURN_PROD_W'(r_dt) * TURN_PROD_W'(r_rate);
    assign w_turn_rnd  = {1'b0, w_turn_prod} + (TURN_PROD_W + 1)'(128);

    // Shorter arc: the clockwise arc less the counter-clockwise arc.
    assign w_e  = $signed({2'b00, r_cur_heading}) - $signed({2'b00, r_target});
    assign w_e2 = ARC_W'(w_e) <<< 1;
    always_comb begin
        if (w_e > 0) begin
            w_diff = w_e2 - FULL_A;
        end else if (w_e < 0) begin
            w_diff = w_e2 + FULL_A;
        end else begin
            w_diff = '0;
        end
    end

    // Heading after the step, before the wrap.
    assign w_h_ext    = $signed(WRAP_W'(r_cur_heading));
    assign w_step_ext = $signed(WRAP_W'(r_step));
    assign w_turned   = r_down ? (w_h_ext - w_step_ext) : (w_h_ext + w_step_ext);

    // Restoring wrap: add or remove a power-of-two number of full turns.
    assign w_mult = FULL_W <<< r_k;
    assign w_cand = r_neg ? (r_v + w_mult) : (r_v - w_mult);
    assign w_take = r_neg ? (w_cand[WRAP_W-1] || (w_cand == '0))
                          : (!w_cand[WRAP_W-1] && (w_cand != '0));
    assign w_fixed = r_v[WRAP_W-1] ? (r_v + FULL_W) : r_v;

    // Fold the heading into plus or minus 90 degrees for the rotation unit.
    always_comb begin
        w_h0 = $signed(HP_W'(r_cur_heading));
        w_h1 = (r_cur_heading >= HEAD_W'(FULL_TURN_Q8)) ? (w_h0 - FULL_H) : w_h0;
        w_h2 = (w_h1 > HALF_H) ? (w_h1 - FULL_H) : w_h1;
        if (w_h2 > QUARTER_H) begin
            w_h3      = HALF_H - w_h2;
            w_neg_cos = 1'b1;
        end else if (w_h2 < -QUARTER_H) begin
            w_h3      = -HALF_H - w_h2;
            w_neg_cos = 1'b1;
        end else begin
            w_h3      = w_h2;
            w_neg_cos = 1'b0;
        end
    end
    assign w_zw   = $signed({w_h3, 8'h00});
    assign w_z0   = w_zw[ANGLE_W-1:0];
    assign w_dist = DIST_W'(r_dt) * DIST_W'(r_speed);

    htm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_MOVE0),
        .i_angle (w_z0),
        .o_done  (w_cordic_done),
        .o_trig  (w_trig)
    );

    // Sine goes through first, then the cosine with its sign restored.
    always_comb begin
        if (r_state == ST_MUL_S) begin
            w_mul_a = w_trig.sin_q30;
        end else if (r_neg_cos) begin
            w_mul_a = -w_trig.cos_q30;
        end else begin
            w_mul_a = w_trig.cos_q30;
        end
    end

    htm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (r_dist),
        .o_p   (w_prod)
    );

    // Offset in pixels Q8, rounded half up, and the saturated new position.
    assign w_off_sum = w_prod + ROUND_HALF;
    assign w_off     = w_off_sum[PROD_W-1:ROUND_SHIFT];
    assign w_off_ext = POS_SUM_W'(w_off);
    assign w_x_ext   = POS_SUM_W'(r_cur_x);
    assign w_y_ext   = POS_SUM_W'(r_cur_y);
    assign w_new_x   = sat_pos(w_x_ext + w_off_ext);
    assign w_new_y   = sat_pos(w_y_ext - w_off_ext);
    assign w_load_x  = sat_pos(POS_SUM_W'(r_start_x));
    assign w_load_y  = sat_pos(POS_SUM_W'(r_start_y));

    assign w_load_out = (r_state == ST_DONE) && (!r_m_valid || m_axis_tready);

    // Sequencer and state updates.
    always_comb begin
        n_state       = r_state;
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_cur_heading = r_cur_heading;
        n_m_valid     = r_m_valid;
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_in_restart) begin
                        n_cur_x       = w_load_x;
                        n_cur_y       = w_load_y;
                        n_cur_heading = r_start_heading;
                    end
                    if (w_in_turn) begin
                        n_state = ST_TURN0;
                    end else if (w_in_move) begin
                        n_state = ST_MOVE0;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_TURN0: n_state = ST_TURN1;
            ST_TURN1: n_state = ST_WRAP;
            ST_WRAP: begin
                if (r_k == '0) begin
                    n_state = ST_WFIX;
                end
            end
            ST_WFIX: begin
                n_cur_heading = w_fixed[HEAD_W-1:0];
                n_state       = r_move_en ? ST_MOVE0 : ST_DONE;
            end
            ST_MOVE0: n_state = ST_CORD;
            ST_CORD: begin
                if (w_cordic_done) begin
                    n_state = ST_MUL_S;
                end
            end
            ST_MUL_S: n_state = ST_MUL_C;
            ST_MUL_C: begin
                n_cur_x = w_new_x;
                n_state = ST_MUL_E;
            end
            ST_MUL_E: begin
                n_cur_y = w_new_y;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_m_valid = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Registers cleared by reset: configuration, position state, control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_start_x       <= '0;
            r_start_y       <= '0;
            r_start_heading <= '0;
            r_cur_x         <= '0;
            r_cur_y         <= '0;
            r_cur_heading   <= '0;
            r_m_valid       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_cur_heading <= n_cur_heading;
            r_m_valid     <= n_m_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_START_X:       r_start_x       <= $signed(i_cfg_wdata);
                    CFG_START_Y:       r_start_y       <= $signed(i_cfg_wdata);
                    CFG_START_HEADING: r_start_heading <= i_cfg_wdata[HEAD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Item fields and datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_move_en <= w_in_move;
            r_target  <= s_axis_tdata[IN_TARGET_LSB +: HEAD_W];
            r_rate    <= s_axis_tdata[IN_RATE_LSB +: RATE_W];
            r_dt      <= s_axis_tdata[IN_DT_LSB +: DT_W];
            r_speed   <= s_axis_tdata[IN_SPEED_LSB +: SPEED_W];
        end
        if (r_state == ST_TURN0) begin
            r_step <= w_turn_rnd[TURN_PROD_W:8];
            r_down <= w_diff[ARC_W-1];
        end
        if (r_state == ST_TURN1) begin
            r_v   <= w_turned;
            r_neg <= w_turned[WRAP_W-1];
            r_k   <= WRAP_K_W'(WRAP_TOP_K);
        end
        if (r_state == ST_WRAP) begin
            if (w_take) begin
                r_v <= w_cand;
            end
            r_k <= r_k - 1'b1;
        end
        if (r_state == ST_MOVE0) begin
            r_dist    <= w_dist;
            r_neg_cos <= w_neg_cos;
        end
        if (w_load_out) begin
            r_m_data <= {{(OUT_DATA_W - OUT_W){1'b0}}, r_cur_heading,
                         w_y_ext[COORD_W-1:0], w_x_ext[COORD_W-1:0]};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // The rotation unit reports completion only while the sequencer waits on it.
    a_cordic_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cordic_done |-> (r_state == ST_CORD))
        else $error("rotation unit finished outside its wait state");

    // The wrap leaves a residue within one turn of zero on the side it started.
    a_wrap_residue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_WRAP) && (r_k == '0)) |=>
        ((r_neg && (r_v <= 0) && (r_v > -FULL_W)) || (!r_neg && (r_v <= FULL_W))))
        else $error("heading wrap residue out of range");

    // A heading written by a turn lies in 0 to 360 degrees.
    a_turned_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WFIX) |=> (r_cur_heading <= HEAD_W'(FULL_TURN_Q8)))
        else $error("turned heading above a full turn");

    // A result word is raised only on leaving the final state.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_DONE))
        else $error("result word raised outside the final state");

endmodule
